// ===== hdl/scam_pkg.sv =====
// ----------------------------------------------------------------------------
// Stall cycle accounting monitor package
// Shared sizes, operation codes, sequencer states and step descriptors.
// ----------------------------------------------------------------------------
package scam_pkg;

  localparam int COMPONENT_COUNT = 32;
  localparam int CYCLE_BITS      = 48;
  localparam int COMP_BITS       = 5;
  localparam int REASON_BITS     = 3;
  localparam int MASK_BITS       = 7;
  localparam int COUNT_BITS      = 6;
  localparam int ENTRY_BITS      = COMP_BITS + REASON_BITS;
  localparam int ENTRY_COUNT     = COMPONENT_COUNT * 8;

  localparam logic [REASON_BITS-1:0] IDLE_REASON = 3'd6;
  localparam logic [REASON_BITS-1:0] ANY_REASON  = 3'd7;
  localparam logic [MASK_BITS-1:0]   IDLE_BIT    = 7'b100_0000;

  localparam logic [2:0] OP_STALL   = 3'd0;
  localparam logic [2:0] OP_UNSTALL = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_REBASE  = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;
  localparam logic [2:0] OP_END     = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_DONE,
    S_CLR
  } state_t;

  // What one memory step does to an entry.
  typedef enum logic [2:0] {
    SK_NONE,
    SK_SET,
    SK_ADD,
    SK_ADDSET,
    SK_RD_TOTAL,
    SK_RD_ANY,
    SK_RD_IDLE
  } slot_kind_t;

  typedef struct packed {
    slot_kind_t             kind;
    logic [REASON_BITS-1:0] k;
  } slot_t;

endpackage

// ===== hdl/scam_ram.sv =====
// ----------------------------------------------------------------------------
// Stall accounting RAM
// Simple dual-port synchronous RAM: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module scam_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/stall_cycle_accounting_monitor_core.sv =====
// ----------------------------------------------------------------------------
// Stall cycle accounting monitor
// Per-component stall reason tracking with interval timers and cycle totals.
// ----------------------------------------------------------------------------
// Every request produces exactly one result. Reason masks, the stalled count
// and the end-of-execution record live in flip-flops and are updated in the
// cycle the request is taken. Interval start stamps and accumulated totals
// sit in two simple dual-port RAMs of COMPONENT_COUNT*8 entries. A request
// runs through three plan slots; a slot with nothing to do takes only a read
// state and a slot that reads or rewrites an entry takes a read state and a
// write state, followed by a done state that loads the output register. The
// next request can be taken as soon as the result appears. Stall rewrites
// zero to three entries, unstall zero to two, a read of a valid component
// reads three, and end of execution and unused codes touch none. Rebase, and
// flush while collection is enabled, walk all 256 entries instead, each one
// taking a read state and, if it is rewritten, a write state. A flush may
// also set the end-of-execution record during its walk. A stalled output
// holds the block in its done state for as long as the stall lasts. After
// reset a clearing pass over all 256 entries zeroes the start stamps, and
// the request input stays stalled meanwhile. Per-entry valid bits on the
// totals make never-written totals read as zero, and a rebase with
// clear_totals drops all totals at once. A new request is taken while the
// previous result still waits at the output register.
module stall_cycle_accounting_monitor_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic                               cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         op,
  input  logic [scam_pkg::COMP_BITS-1:0]     component,
  input  logic [scam_pkg::REASON_BITS-1:0]   reason,
  input  logic [scam_pkg::CYCLE_BITS-1:0]    cycle,
  input  logic                               clear_totals,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [scam_pkg::CYCLE_BITS-1:0]    total_cycles,
  output logic [scam_pkg::CYCLE_BITS-1:0]    stalled_not_idle,
  output logic [scam_pkg::MASK_BITS-1:0]     reason_mask,
  output logic [scam_pkg::COUNT_BITS-1:0]    stalled_count,
  output logic [scam_pkg::CYCLE_BITS-1:0]    end_cycle,
  output logic                               finished
);
  import scam_pkg::*;

  // Sequencer and item registers.
  state_t                 state, state_next;
  logic                   collect_en;
  logic                   sweep, sweep_flush;
  slot_t                  plan [3];
  logic [1:0]             slot;
  logic [ENTRY_BITS-1:0]  idx;
  slot_t                  cur;
  logic                   cur_last;
  logic [ENTRY_BITS-1:0]  ent;
  logic [COMP_BITS-1:0]   comp_q;
  logic                   comp_ok_q;
  logic [CYCLE_BITS-1:0]  now_q;
  logic [CYCLE_BITS-1:0]  total_q, tmp_q, sni_q;

  // Flip-flop state.
  logic [MASK_BITS-1:0]   reason_bits [COMPONENT_COUNT];
  logic [COUNT_BITS-1:0]  stalled_total;
  logic [CYCLE_BITS-1:0]  execution_end;
  logic                   end_signalled;
  logic [ENTRY_COUNT-1:0] acc_valid;

  // RAM ports.
  logic                   rd_en;
  logic [ENTRY_BITS-1:0]  rd_addr;
  logic [CYCLE_BITS-1:0]  start_rd, acc_rd;
  logic                   start_we, acc_we;
  logic [ENTRY_BITS-1:0]  start_waddr;
  logic [CYCLE_BITS-1:0]  start_wdata;
  logic [CYCLE_BITS-1:0]  acc_sum;

  // Request decode.
  logic                   accept;
  logic                   comp_ok;
  logic [MASK_BITS-1:0]   m, rbit, mask_new;
  logic                   mask_we;
  logic [COUNT_BITS-1:0]  st_new;
  logic                   end_set, fin_set, sweep_start, flush_start;
  slot_t                  plan_next [3];

  // Step selection.
  slot_t                  act;
  logic [ENTRY_BITS-1:0]  act_addr;
  logic                   act_last, act_end;
  logic [COMP_BITS-1:0]   sc;
  logic [REASON_BITS-1:0] sk;
  logic [MASK_BITS-1:0]   sm;
  logic                   sm_has;

  // Read-modify-write datapath.
  logic [CYCLE_BITS-1:0]  start_val, acc_val, added;

  logic [COMPONENT_COUNT-1:0] nz;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // Decode the request against the component's current reason mask.
  always_comb begin
    comp_ok     = (32'(component) < COMPONENT_COUNT);
    m           = reason_bits[component];
    rbit        = MASK_BITS'(1) << reason;
    mask_new    = m;
    mask_we     = 1'b0;
    st_new      = stalled_total;
    end_set     = 1'b0;
    fin_set     = 1'b0;
    sweep_start = 1'b0;
    flush_start = 1'b0;
    for (int i = 0; i < 3; i++) begin
      plan_next[i] = '{kind: SK_NONE, k: ANY_REASON};
    end
    unique case (op)
      OP_STALL: begin
        if (comp_ok && reason != ANY_REASON && (m & rbit) == '0 &&
            !(reason == IDLE_REASON && m != '0)) begin
          mask_we = 1'b1;
          // A real stall first closes the idle interval, which also closes
          // the any-stall interval; the any timer then reopens right away.
          if (m[6]) begin
            if (collect_en) begin
              plan_next[0] = '{kind: SK_ADD, k: IDLE_REASON};
              plan_next[1] = '{kind: SK_ADDSET, k: ANY_REASON};
            end else begin
              plan_next[1] = '{kind: SK_SET, k: ANY_REASON};
            end
            mask_new = rbit;
            end_set  = (32'(stalled_total) >= COMPONENT_COUNT);
          end else begin
            mask_new = m | rbit;
            if (m == '0) begin
              plan_next[1] = '{kind: SK_SET, k: ANY_REASON};
              st_new       = stalled_total + COUNT_BITS'(1);
              end_set      = (32'(st_new) >= COMPONENT_COUNT);
            end
          end
          plan_next[2] = '{kind: SK_SET, k: reason};
        end
      end
      OP_UNSTALL: begin
        if (comp_ok && reason != ANY_REASON && (m & rbit) != '0) begin
          mask_we  = 1'b1;
          mask_new = m & ~rbit;
          if (collect_en) begin
            plan_next[0] = '{kind: SK_ADD, k: reason};
          end
          if (m == rbit) begin
            st_new = stalled_total - COUNT_BITS'(1);
            if (collect_en) begin
              plan_next[1] = '{kind: SK_ADD, k: ANY_REASON};
            end
          end
        end
      end
      OP_READ: begin
        if (comp_ok) begin
          plan_next[0] = '{kind: SK_RD_TOTAL, k: reason};
          plan_next[1] = '{kind: SK_RD_ANY, k: ANY_REASON};
          plan_next[2] = '{kind: SK_RD_IDLE, k: IDLE_REASON};
        end
      end
      OP_REBASE: begin
        sweep_start = 1'b1;
      end
      OP_FLUSH: begin
        sweep_start = collect_en;
        flush_start = collect_en;
      end
      OP_END: begin
        end_set = (32'(stalled_total) < COMPONENT_COUNT);
        fin_set = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Choose the next memory step, either from the request's plan or from the
  // walk over all entries.
  always_comb begin
    sc       = idx[ENTRY_BITS-1:REASON_BITS];
    sk       = idx[REASON_BITS-1:0];
    sm       = reason_bits[sc];
    sm_has   = (sm & (MASK_BITS'(1) << sk)) != '0;
    act_end  = 1'b0;
    if (sweep) begin
      act      = '{kind: SK_NONE, k: sk};
      act_addr = idx;
      act_last = (32'(idx) == ENTRY_COUNT - 1);
      if (sweep_flush) begin
        // Closing and reopening each set reason; the any timer only closes
        // when that reason is the component's only one.
        if (sk == ANY_REASON) begin
          if ($onehot(sm)) begin
            act.kind = SK_ADDSET;
            act_end  = (32'(stalled_total) >= COMPONENT_COUNT);
          end
        end else if (sm_has) begin
          act.kind = SK_ADDSET;
        end
      end else begin
        if ((sk == ANY_REASON) ? (sm != '0) : sm_has) begin
          act.kind = SK_SET;
        end
      end
    end else begin
      act      = plan[slot];
      act_addr = {comp_q, plan[slot].k};
      act_last = (slot == 2'd2);
    end
  end

  // RAM read and write control; the clearing pass after reset zeroes one start stamp per cycle.
  always_comb begin
    start_val   = start_rd;
    acc_val     = acc_valid[ent] ? acc_rd : '0;
    added       = now_q - start_val;
    acc_sum     = acc_val + added;
    start_we    = (state == S_CLR) ||
                  ((state == S_WR) && (cur.kind == SK_SET || cur.kind == SK_ADDSET));
    start_waddr = (state == S_CLR) ? idx : ent;
    start_wdata = (state == S_CLR) ? '0 : now_q;
    acc_we      = (state == S_WR) && (cur.kind == SK_ADD || cur.kind == SK_ADDSET);
    rd_en       = (state == S_RD) && (act.kind != SK_NONE);
    rd_addr     = act_addr;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (32'(idx) == ENTRY_COUNT - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (act.kind != SK_NONE) begin
          state_next = S_WR;
        end else if (act_last) begin
          state_next = S_DONE;
        end
      end
      S_WR: begin
        state_next = cur_last ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      collect_en    <= 1'b1;
      stalled_total <= COUNT_BITS'(COMPONENT_COUNT);
      execution_end <= '0;
      end_signalled <= 1'b0;
      acc_valid     <= '0;
      out_valid     <= 1'b0;
      sweep         <= 1'b0;
      sweep_flush   <= 1'b0;
      slot          <= '0;
      idx           <= '0;
      for (int i = 0; i < COMPONENT_COUNT; i++) begin
        reason_bits[i] <= IDLE_BIT;
      end
    end else begin
      state <= state_next;
      if (cfg_write) begin
        collect_en <= cfg_data;
      end
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (state == S_CLR) begin
        idx <= idx + ENTRY_BITS'(1);
      end

      if (accept) begin
        sweep       <= sweep_start;
        sweep_flush <= flush_start;
        slot        <= '0;
        idx         <= '0;
        if (mask_we) begin
          reason_bits[component] <= mask_new;
        end
        stalled_total <= st_new;
        if (end_set) begin
          execution_end <= cycle;
        end
        if (fin_set) begin
          end_signalled <= 1'b1;
        end
        if (op == OP_REBASE && clear_totals) begin
          acc_valid <= '0;
        end
      end

      if (state == S_RD) begin
        if (sweep) begin
          idx <= idx + ENTRY_BITS'(1);
        end else begin
          slot <= slot + 2'd1;
        end
        if (act_end) begin
          execution_end <= now_q;
        end
      end

      if (acc_we) begin
        acc_valid[ent] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      comp_q    <= component;
      comp_ok_q <= comp_ok;
      now_q     <= cycle;
      total_q   <= '0;
      sni_q     <= '0;
      plan      <= plan_next;
    end
    if (state == S_RD && act.kind != SK_NONE) begin
      cur      <= act;
      cur_last <= act_last;
      ent      <= act_addr;
    end
    if (state == S_WR) begin
      case (cur.kind)
        SK_ADD, SK_ADDSET: begin
          if (cur.k != ANY_REASON) begin
            total_q <= total_q + added;
          end
        end
        SK_RD_TOTAL: total_q <= acc_val;
        SK_RD_ANY:   tmp_q   <= acc_val;
        SK_RD_IDLE:  sni_q   <= tmp_q - acc_val;
        default: begin
        end
      endcase
    end
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      total_cycles     <= total_q;
      stalled_not_idle <= sni_q;
      reason_mask      <= comp_ok_q ? reason_bits[comp_q] : '0;
      stalled_count    <= stalled_total;
      end_cycle        <= execution_end;
      finished         <= end_signalled;
    end
  end

  scam_ram #(.DEPTH(ENTRY_COUNT), .WIDTH(CYCLE_BITS)) u_start_ram (
    .clk   (clk),
    .we    (start_we),
    .waddr (start_waddr),
    .wdata (start_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (start_rd)
  );

  scam_ram #(.DEPTH(ENTRY_COUNT), .WIDTH(CYCLE_BITS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (ent),
    .wdata (acc_sum),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (acc_rd)
  );

  always_comb begin
    for (int i = 0; i < COMPONENT_COUNT; i++) begin
      nz[i] = (reason_bits[i] != '0);
    end
  end

`ifndef ASSERT_OFF
  // The stalled count always matches the number of components with a reason.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    32'(stalled_total) == $countones(nz))
    else $error("stalled count out of step with reason masks");

  // Once signalled, end of execution stays signalled.
  a_finished_sticky: assert property (@(posedge clk) disable iff (rst)
    end_signalled |=> end_signalled)
    else $error("end of execution flag dropped");

  // A finished request reaches the output register when it is free.
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !(out_valid && out_stall)) |=> (out_valid && state == S_IDLE))
    else $error("result not delivered from done state");

  // Memory writes only happen in the write phase of a step or while clearing.
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    (start_we || acc_we) |-> (state == S_WR || state == S_CLR))
    else $error("RAM write outside a read-modify-write step");
`endif

endmodule
